>>> rtl/core/julia_escape_time_pixel_assert.svh
// Assertion macros for the Julia escape-time pixel engine.
// Used by the top level; active only when SYNTHESIS is not defined.
`ifndef JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
`define JETP_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("jetp assertion failed");
`define JETP_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("jetp assertion failed");
`else
`define JETP_ASSERT_NOW(lbl, cond, prop)
`define JETP_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

>>> rtl/core/jetp_pkg.sv
// Shared types, constants and functions of the Julia escape-time pixel engine.
// No dependencies.
package jetp_pkg;

  localparam int FRAC_BITS  = 26;
  localparam int ITER_LIMIT = 300;
  localparam int COORD_W    = 32;
  localparam int STEP_W     = 31;
  localparam int IDX_W      = 10;
  localparam int OUT_CNT_W  = 9;
  localparam int COLOR_W    = 24;
  localparam int LIM_W      = $clog2(ITER_LIMIT + 1);
  localparam int CNT_W      = (LIM_W > OUT_CNT_W) ? LIM_W : OUT_CNT_W;

  localparam int PROD_W = 2 * COORD_W;
  localparam int SQ_W   = PROD_W - 1 - FRAC_BITS;
  localparam int NX_W   = PROD_W + 2 - FRAC_BITS;
  localparam int MAP_W  = IDX_W + STEP_W + 3;
  localparam int SAT_W  = (MAP_W > NX_W) ? MAP_W : NX_W;

  localparam logic [SQ_W:0] ESC_BOUND = (SQ_W + 1)'(4) << FRAC_BITS;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(ITER_LIMIT);
  localparam logic [CNT_W-1:0] CNT_HIGH  = CNT_W'(250);
  localparam logic [CNT_W-1:0] CNT_MID   = CNT_W'(100);

  localparam logic [COLOR_W-1:0] COLOR_INSIDE = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR_HIGH   = 24'hFFFF00;
  localparam logic [COLOR_W-1:0] COLOR_MID    = 24'hFF0000;
  localparam logic [COLOR_W-1:0] COLOR_LOW    = 24'hFFFFFF;

  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_EDGE  = 3'd0,
    REG_TOP_EDGE   = 3'd1,
    REG_STEP_REAL  = 3'd2,
    REG_STEP_IMAG  = 3'd3,
    REG_CONST_REAL = 3'd4,
    REG_CONST_IMAG = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic [IDX_W-1:0]          col;
    logic [IDX_W-1:0]          row;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [CNT_W-1:0]          count;
    logic                      done;
  } iter_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
      input logic signed [SAT_W-1:0] v);
    logic [SAT_W-COORD_W:0] hi;
    hi = v[SAT_W-1:COORD_W-1];
    if ((hi == '0) || (hi == '1)) begin
      return v[COORD_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/core/jetp_map.sv
// Pixel to start point mapping: multiply stage, then add and saturate stage.
// Depends on jetp_pkg.
module jetp_map (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [jetp_pkg::IDX_W-1:0]          col,
  input  logic [jetp_pkg::IDX_W-1:0]          row,
  input  logic signed [jetp_pkg::COORD_W-1:0] left_edge,
  input  logic signed [jetp_pkg::COORD_W-1:0] top_edge,
  input  logic [jetp_pkg::STEP_W-1:0]         step_real,
  input  logic [jetp_pkg::STEP_W-1:0]         step_imag,
  output logic                                out_valid,
  output jetp_pkg::iter_t                     out_data
);

  localparam int PW = jetp_pkg::IDX_W + jetp_pkg::STEP_W;

  logic                       v1;
  logic [jetp_pkg::IDX_W-1:0] col1;
  logic [jetp_pkg::IDX_W-1:0] row1;
  logic [PW-1:0]              prod_re;
  logic [PW-1:0]              prod_im;
  logic signed [jetp_pkg::SAT_W-1:0] x_full;
  logic signed [jetp_pkg::SAT_W-1:0] y_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col1    <= col;
      row1    <= row;
      prod_re <= PW'(col) * PW'(step_real);
      prod_im <= PW'(row) * PW'(step_imag);
    end
  end

  always_comb begin
    x_full = jetp_pkg::SAT_W'(left_edge) + $signed({{(jetp_pkg::SAT_W - PW){1'b0}}, prod_re});
    y_full = jetp_pkg::SAT_W'(top_edge) - $signed({{(jetp_pkg::SAT_W - PW){1'b0}}, prod_im});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.col   <= col1;
      out_data.row   <= row1;
      out_data.x     <= jetp_pkg::sat_coord(x_full);
      out_data.y     <= jetp_pkg::sat_coord(y_full);
      out_data.count <= '0;
      out_data.done  <= 1'b0;
    end
  end

endmodule

>>> rtl/core/jetp_iter.sv
// One z = z*z + c iteration cell: product stage, then escape test and update.
// Depends on jetp_pkg.
module jetp_iter (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  jetp_pkg::iter_t in_data,
  input  jetp_pkg::cplx_t jc,
  output logic            out_valid,
  output jetp_pkg::iter_t out_data
);

  logic                                 va;
  jetp_pkg::iter_t                      da;
  logic signed [jetp_pkg::PROD_W-1:0]   pxx;
  logic signed [jetp_pkg::PROD_W-1:0]   pyy;
  logic signed [jetp_pkg::PROD_W-1:0]   pxy;
  logic signed [jetp_pkg::PROD_W-1:0]   xx_s;
  logic signed [jetp_pkg::PROD_W-1:0]   yy_s;
  logic signed [jetp_pkg::PROD_W-1:0]   xy_s;
  logic [jetp_pkg::SQ_W-1:0]            xx;
  logic [jetp_pkg::SQ_W-1:0]            yy;
  logic [jetp_pkg::SQ_W:0]              mag;
  logic signed [jetp_pkg::NX_W-1:0]     nx;
  logic signed [jetp_pkg::NX_W-1:0]     ny;
  logic                                 escape;
  jetp_pkg::iter_t                      d_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      da  <= in_data;
      pxx <= in_data.x * in_data.x;
      pyy <= in_data.y * in_data.y;
      pxy <= in_data.x * in_data.y;
    end
  end

  // arithmetic shifts give floor division
  always_comb begin
    xx_s   = pxx >>> jetp_pkg::FRAC_BITS;
    yy_s   = pyy >>> jetp_pkg::FRAC_BITS;
    xy_s   = pxy >>> (jetp_pkg::FRAC_BITS - 1);
    xx     = xx_s[jetp_pkg::SQ_W-1:0];
    yy     = yy_s[jetp_pkg::SQ_W-1:0];
    mag    = {1'b0, xx} + {1'b0, yy};
    escape = mag > jetp_pkg::ESC_BOUND;
    nx     = $signed({{(jetp_pkg::NX_W - jetp_pkg::SQ_W){1'b0}}, xx})
           - $signed({{(jetp_pkg::NX_W - jetp_pkg::SQ_W){1'b0}}, yy})
           + jetp_pkg::NX_W'(jc.re);
    ny     = xy_s[jetp_pkg::NX_W-1:0] + jetp_pkg::NX_W'(jc.im);
    d_next = da;
    if (!da.done) begin
      if (escape) begin
        d_next.done = 1'b1;
      end else begin
        d_next.x     = jetp_pkg::sat_coord(jetp_pkg::SAT_W'(nx));
        d_next.y     = jetp_pkg::sat_coord(jetp_pkg::SAT_W'(ny));
        d_next.count = da.count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= d_next;
    end
  end

endmodule

>>> rtl/core/jetp_color.sv
// Color banding and output word register.
// Depends on jetp_pkg.
module jetp_color (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             in_valid,
  input  jetp_pkg::iter_t                  in_data,
  output logic                             out_valid,
  output logic [jetp_pkg::IDX_W-1:0]       out_col,
  output logic [jetp_pkg::IDX_W-1:0]       out_row,
  output logic [jetp_pkg::OUT_CNT_W-1:0]   iter_count,
  output logic [jetp_pkg::COLOR_W-1:0]     pixel_color
);

  logic [jetp_pkg::COLOR_W-1:0] color_next;

  always_comb begin
    if (in_data.count == jetp_pkg::CNT_LIMIT) begin
      color_next = jetp_pkg::COLOR_INSIDE;
    end else if (in_data.count > jetp_pkg::CNT_HIGH) begin
      color_next = jetp_pkg::COLOR_HIGH;
    end else if (in_data.count > jetp_pkg::CNT_MID) begin
      color_next = jetp_pkg::COLOR_MID;
    end else begin
      color_next = jetp_pkg::COLOR_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_col     <= in_data.col;
      out_row     <= in_data.row;
      iter_count  <= in_data.count[jetp_pkg::OUT_CNT_W-1:0];
      pixel_color <= color_next;
    end
  end

endmodule

>>> rtl/core/julia_escape_time_pixel.sv
// Top level of the Julia escape-time pixel engine: config registers,
// mapping stages, chain of iteration cells, color stage.
// Depends on jetp_pkg, jetp_map, jetp_iter, jetp_color and the assert header.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata: col, row
//   m_*      out  m_tvalid/m_tready  tdata: col, row, iter_count, pixel_color
//   cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One pixel enters per cycle while the output is not held; the pipeline has
// two mapping stages, two stages per iteration cell and one output stage.
// Depth is set by the unrolled chain of ITER_LIMIT iteration cells.
// Reset clears all valid bits and loads the config defaults.
// A held output word freezes the whole pipeline; nothing is dropped.
module julia_escape_time_pixel (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [23:0]                       s_tdata,   // col[9:0], row[19:10], zero pad
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [55:0]                       m_tdata,   // col, row, iter_count, pixel_color, pad
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jetp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jetp_pkg::COORD_W-1:0]      cfg_data
);

  `include "julia_escape_time_pixel_assert.svh"

  localparam int N = jetp_pkg::ITER_LIMIT;

  logic signed [jetp_pkg::COORD_W-1:0] left_edge;
  logic signed [jetp_pkg::COORD_W-1:0] top_edge;
  logic [jetp_pkg::STEP_W-1:0]         step_real;
  logic [jetp_pkg::STEP_W-1:0]         step_imag;
  jetp_pkg::cplx_t                     jc;

  logic                                adv;
  logic                                vchain [N+1];
  jetp_pkg::iter_t                     dchain [N+1];
  logic [jetp_pkg::IDX_W-1:0]          out_col;
  logic [jetp_pkg::IDX_W-1:0]          out_row;
  logic [jetp_pkg::OUT_CNT_W-1:0]      iter_count;
  logic [jetp_pkg::COLOR_W-1:0]        pixel_color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge <= -32'sd134217728;
      top_edge  <= 32'sd134217728;
      step_real <= 31'd262144;
      step_imag <= 31'd262144;
      jc.re     <= -32'sd53687091;
      jc.im     <= 32'sd10468982;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        jetp_pkg::REG_LEFT_EDGE:  left_edge <= cfg_data;
        jetp_pkg::REG_TOP_EDGE:   top_edge  <= cfg_data;
        jetp_pkg::REG_STEP_REAL:  step_real <= cfg_data[jetp_pkg::STEP_W-1:0];
        jetp_pkg::REG_STEP_IMAG:  step_imag <= cfg_data[jetp_pkg::STEP_W-1:0];
        jetp_pkg::REG_CONST_REAL: jc.re     <= cfg_data;
        jetp_pkg::REG_CONST_IMAG: jc.im     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  jetp_map u_map (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_tvalid),
    .col       (s_tdata[9:0]),
    .row       (s_tdata[19:10]),
    .left_edge (left_edge),
    .top_edge  (top_edge),
    .step_real (step_real),
    .step_imag (step_imag),
    .out_valid (vchain[0]),
    .out_data  (dchain[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_iter
    jetp_iter u_iter (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (vchain[i]),
      .in_data   (dchain[i]),
      .jc        (jc),
      .out_valid (vchain[i+1]),
      .out_data  (dchain[i+1])
    );
  end

  jetp_color u_color (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (vchain[N]),
    .in_data     (dchain[N]),
    .out_valid   (m_tvalid),
    .out_col     (out_col),
    .out_row     (out_row),
    .iter_count  (iter_count),
    .pixel_color (pixel_color)
  );

  assign m_tdata = {3'b000, pixel_color, iter_count, out_row, out_col};

  `JETP_ASSERT_NOW(a_count_limit, m_tvalid, iter_count <= jetp_pkg::OUT_CNT_W'(N))
  `JETP_ASSERT_NOW(a_end_done, vchain[N], dchain[N].done || (dchain[N].count == jetp_pkg::CNT_LIMIT))
  `JETP_ASSERT_NEXT(a_stall_hold, !s_tready, m_tvalid)

endmodule

>>> bench/julia_pixel_checker.sv
// Scoreboard for julia_escape_time_pixel: watches the pixel, result and register
// channels, predicts escape count and color per pixel, and checks results in order.
// Depends on jetp_pkg.
`timescale 1ns / 100ps

module julia_pixel_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // col[9:0], row[19:10], zero pad
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [55:0]                    m_tdata,   // col, row, iter_count, pixel_color, pad
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [jetp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jetp_pkg::COORD_W-1:0]   cfg_data,
  output int                             errors,
  output int                             pending
);
  import jetp_pkg::*;

  localparam int LEFT_RST  = -134217728;
  localparam int TOP_RST   = 134217728;
  localparam int STEP_RST  = 262144;
  localparam int CRE_RST   = -53687091;
  localparam int CIM_RST   = 10468982;
  localparam int BAND_HIGH = 250;
  localparam int BAND_MID  = 100;

  localparam logic [COLOR_W-1:0] SHADE_INSIDE = 24'h000000;
  localparam logic [COLOR_W-1:0] SHADE_HIGH   = 24'hFFFF00;
  localparam logic [COLOR_W-1:0] SHADE_MID    = 24'hFF0000;
  localparam logic [COLOR_W-1:0] SHADE_LOW    = 24'hFFFFFF;

  localparam longint COORD_HI  = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_LO  = -(longint'(1) <<< (COORD_W - 1));
  localparam longint RADIUS_SQ = longint'(4) <<< FRAC_BITS;

  typedef struct packed {
    logic [IDX_W-1:0]     col;
    logic [IDX_W-1:0]     row;
    logic [OUT_CNT_W-1:0] count;
    logic [COLOR_W-1:0]   color;
  } pixel_result_t;

  logic signed [COORD_W-1:0] left_edge, top_edge, const_real, const_imag;
  logic [STEP_W-1:0]         step_real, step_imag;
  pixel_result_t             expected_pixels[$];

  function automatic longint clamp32(input longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  function automatic pixel_result_t escape_result(input logic [IDX_W-1:0] col,
                                                  input logic [IDX_W-1:0] row);
    longint        x, y, xx, yy, xy2;
    int            n;
    bit            escaped;
    pixel_result_t r;
    x = clamp32(longint'(left_edge) + longint'(col) * longint'(step_real));
    y = clamp32(longint'(top_edge) - longint'(row) * longint'(step_imag));
    n = 0;
    escaped = 1'b0;
    while (n < ITER_LIMIT && !escaped) begin
      xx = (x * x) >>> FRAC_BITS;
      yy = (y * y) >>> FRAC_BITS;
      xy2 = (x * y) >>> (FRAC_BITS - 1);
      if (xx + yy > RADIUS_SQ) begin
        escaped = 1'b1;
      end else begin
        x = clamp32(xx - yy + longint'(const_real));
        y = clamp32(xy2 + longint'(const_imag));
        n++;
      end
    end
    r.col = col;
    r.row = row;
    r.count = OUT_CNT_W'(n);
    if (n == ITER_LIMIT) r.color = SHADE_INSIDE;
    else if (n > BAND_HIGH) r.color = SHADE_HIGH;
    else if (n > BAND_MID) r.color = SHADE_MID;
    else r.color = SHADE_LOW;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    pixel_result_t want, got;
    if (rst) begin
      left_edge = LEFT_RST;
      top_edge = TOP_RST;
      step_real = STEP_W'(STEP_RST);
      step_imag = STEP_W'(STEP_RST);
      const_real = CRE_RST;
      const_imag = CIM_RST;
      expected_pixels.delete();
      errors = 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_pixels.push_back(escape_result(s_tdata[IDX_W-1:0],
                                                s_tdata[2*IDX_W-1:IDX_W]));
      if (m_tvalid && m_tready) begin
        got.col = m_tdata[IDX_W-1:0];
        got.row = m_tdata[2*IDX_W-1:IDX_W];
        got.count = m_tdata[2*IDX_W +: OUT_CNT_W];
        got.color = m_tdata[2*IDX_W+OUT_CNT_W +: COLOR_W];
        if (expected_pixels.size() == 0) begin
          $error("result word with no pixel pending: col %0d row %0d", got.col, got.row);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          compare_field("out_col", 32'(want.col), 32'(got.col));
          compare_field("out_row", 32'(want.row), 32'(got.row));
          compare_field("iter_count", 32'(want.count), 32'(got.count));
          compare_field("pixel_color", 32'(want.color), 32'(got.color));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEFT_EDGE:  left_edge = cfg_data;
          REG_TOP_EDGE:   top_edge = cfg_data;
          REG_STEP_REAL:  step_real = cfg_data[STEP_W-1:0];
          REG_STEP_IMAG:  step_imag = cfg_data[STEP_W-1:0];
          REG_CONST_REAL: const_real = cfg_data;
          REG_CONST_IMAG: const_imag = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_pixels.size();
  end

endmodule

>>> bench/tb_julia_escape_time_pixel.sv
// Top of the julia_escape_time_pixel bench: clock, reset, pixel and register
// stimulus, result-side backpressure, watchdog and verdict.
// Depends on jetp_pkg, julia_escape_time_pixel and julia_pixel_checker.
`timescale 1ns / 100ps

module tb_julia_escape_time_pixel;
  import jetp_pkg::*;

  localparam int PIPE_LATENCY = 2 + 2 * ITER_LIMIT + 1;
  localparam int QUIET_LIMIT  = 8 * PIPE_LATENCY;
  localparam int PHASES       = 12;
  localparam int PHASE_PIXELS = 107;
  localparam int IDX_MAX      = (1 << IDX_W) - 1;
  localparam int ONE          = 1 << FRAC_BITS;
  localparam int S_PAD        = 24 - 2 * IDX_W;
  localparam int NUM_REGS     = REG_CONST_IMAG + 1;
  localparam int GAP_HEAVY    = 83;
  localparam int GAP_LIGHT    = 16;

  localparam int                 REG_SPARE_LO = REG_CONST_IMAG + 1;
  localparam int                 REG_SPARE_HI = REG_CONST_IMAG + 2;
  localparam logic [COORD_W-1:0] WORD_MIN     = 32'h8000_0000;
  localparam logic [COORD_W-1:0] WORD_MAX     = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] WORD_ONES    = 32'hFFFF_FFFF;

  typedef enum int {WIN_CLASSIC, WIN_SLOW, WIN_WILD, WIN_CORNER} window_kind_t;
  typedef enum int {FLOW_FREE, FLOW_SENDER_GAPS, FLOW_RECEIVER_STALLS, FLOW_BOTH} flow_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [23:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [55:0]          m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;

  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   quiet = 0;
  int                   errors;
  int                   pending;
  logic [COORD_W-1:0]   cfg_plan [NUM_REGS];

  julia_escape_time_pixel u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  julia_pixel_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int spread(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // called at a falling edge, returns at the falling edge after the handshake
  task automatic send_pixel(input int col, input int row);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{S_PAD{1'b0}}, IDX_W'(row), IDX_W'(col)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [COORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // unused indexes get random words too; they must change nothing
  task automatic apply_plan;
    for (int i = REG_LEFT_EDGE; i < NUM_REGS; i++) write_reg(i, cfg_plan[i]);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] corner_word();
    case ($urandom_range(0, 3))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      default: return WORD_ONES;
    endcase
  endfunction

  task automatic plan_window(input window_kind_t kind);
    case (kind)
      WIN_CLASSIC: begin
        cfg_plan[REG_LEFT_EDGE] = spread(-2 * ONE - ONE / 4, -2 * ONE + ONE / 4);
        cfg_plan[REG_TOP_EDGE] = spread(2 * ONE - ONE / 4, 2 * ONE + ONE / 4);
        cfg_plan[REG_STEP_REAL] = spread(ONE / 512, ONE / 128);
        cfg_plan[REG_STEP_IMAG] = spread(ONE / 512, ONE / 128);
        cfg_plan[REG_CONST_REAL] = spread(-ONE, ONE / 2);
        cfg_plan[REG_CONST_IMAG] = spread(-ONE * 4 / 5, ONE * 4 / 5);
      end
      WIN_SLOW: begin
        // c just past the parabolic point: long passage near z = 1/2
        cfg_plan[REG_LEFT_EDGE] = spread(-3 * ONE / 2 - ONE / 16, -3 * ONE / 2 + ONE / 16);
        cfg_plan[REG_TOP_EDGE] = spread(-ONE / 32, ONE / 32);
        cfg_plan[REG_STEP_REAL] = spread(ONE / 512, ONE / 256);
        cfg_plan[REG_STEP_IMAG] = spread(0, ONE / 8192);
        cfg_plan[REG_CONST_REAL] = spread(ONE / 4, ONE / 4 + 40000);
        cfg_plan[REG_CONST_IMAG] = spread(-1000, 1000);
      end
      WIN_WILD: begin
        for (int i = REG_LEFT_EDGE; i < NUM_REGS; i++) cfg_plan[i] = $urandom;
      end
      default: begin
        for (int i = REG_LEFT_EDGE; i < NUM_REGS; i++) cfg_plan[i] = corner_word();
      end
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset window
    send_pixel(0, 0);
    send_pixel(IDX_MAX, IDX_MAX);
    send_pixel(0, IDX_MAX);
    send_pixel(IDX_MAX, 0);
    send_pixel(512, 512);
    send_pixel(511, 512);
    send_pixel(300, 600);
    send_pixel(700, 400);
    drain;

    // start points clamp at both bounds, iterates saturate
    cfg_plan[REG_LEFT_EDGE] = WORD_MIN;
    cfg_plan[REG_TOP_EDGE] = WORD_MAX;
    cfg_plan[REG_STEP_REAL] = WORD_ONES;
    cfg_plan[REG_STEP_IMAG] = WORD_MAX;
    cfg_plan[REG_CONST_REAL] = WORD_MAX;
    cfg_plan[REG_CONST_IMAG] = WORD_MIN;
    apply_plan;
    send_pixel(0, 0);
    send_pixel(IDX_MAX, IDX_MAX);
    send_pixel(1, 0);
    send_pixel(0, 1);
    send_pixel(IDX_MAX, 0);
    send_pixel(0, IDX_MAX);
    drain;

    // real axis with c about 1e-4 past 1/4: all four color bands
    cfg_plan[REG_LEFT_EDGE] = -3 * ONE / 2;
    cfg_plan[REG_TOP_EDGE] = 0;
    cfg_plan[REG_STEP_REAL] = 3 * ONE / 1024;
    cfg_plan[REG_STEP_IMAG] = 0;
    cfg_plan[REG_CONST_REAL] = ONE / 4 + 6711;
    cfg_plan[REG_CONST_IMAG] = 0;
    apply_plan;
    send_pixel(0, $urandom_range(0, IDX_MAX));
    send_pixel(200, $urandom_range(0, IDX_MAX));
    send_pixel(320, $urandom_range(0, IDX_MAX));
    send_pixel(400, $urandom_range(0, IDX_MAX));
    send_pixel(512, $urandom_range(0, IDX_MAX));
    send_pixel(600, $urandom_range(0, IDX_MAX));
    send_pixel(680, $urandom_range(0, IDX_MAX));
    send_pixel(760, $urandom_range(0, IDX_MAX));
    send_pixel(IDX_MAX, $urandom_range(0, IDX_MAX));
    drain;

    for (int p = 0; p < PHASES; p++) begin
      case (flow_t'(p % 4))
        FLOW_FREE: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        FLOW_SENDER_GAPS: begin
          send_idle_pct = GAP_HEAVY;
          recv_stall_pct = 0;
        end
        FLOW_RECEIVER_STALLS: begin
          send_idle_pct = 0;
          recv_stall_pct = GAP_HEAVY;
        end
        default: begin
          send_idle_pct = GAP_LIGHT;
          recv_stall_pct = GAP_LIGHT;
        end
      endcase
      plan_window(window_kind_t'((p + p / 4) % 4));
      apply_plan;
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        send_pixel($urandom_range(0, IDX_MAX), $urandom_range(0, IDX_MAX));
        if (k == PHASE_PIXELS / 2) drain;
      end
      drain;
    end

    repeat (PIPE_LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
